[rtl/ilfc_pkg.sv]
package ilfc_pkg;

  localparam int unsigned DepthDefault = 256;
  localparam int unsigned WordW        = 32;
  localparam int unsigned KindW        = 3;
  localparam int unsigned PosW         = 8;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned CountW       = 9;
  localparam int unsigned CapW         = 10;
  localparam logic [CapW-1:0] CapMax   = 10'd1023;
  localparam logic [CapW-1:0] CapOne   = 10'd1;

  typedef enum logic [KindW-1:0] {
    KIND_INSERT = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_LOOKUP = 3'd2,
    KIND_PUSH   = 3'd3,
    KIND_POP    = 3'd4
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_INDEX = 2'd1,
    ST_UNDER = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SHIFT = 3'b010,
    S_FIN   = 3'b100
  } state_e;

endpackage

[rtl/ilfc_mem.sv]
module ilfc_mem #(
  parameter int unsigned DEPTH = ilfc_pkg::DepthDefault,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [ilfc_pkg::WordW-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [ilfc_pkg::WordW-1:0] rdata_o
);
  import ilfc_pkg::*;

  logic [WordW-1:0] mem [DEPTH];
  logic [WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/indexed_list_with_fib_capacity_top.sv]
// Channel | Direction | Signals
// in      | input     | in_valid_i, in_ready_o, kind_i, position_i, item_value_i
// out     | output    | out_valid_o, out_ready_i, read_value_o, status_o,
//         |           | item_count_o, capacity_now_o
// One item at a time. Push, errors and insert at the tail move no words; lookup
// and pop read one word; other inserts and remove move the tail, from position to
// fill, one word per cycle through the memory's single read and single write port.
// Reset empties the list and sets all capacity terms to one; no memory sweep.
// A held output adds the wait; the next item is taken while a result waits.
module indexed_list_with_fib_capacity_top #(
  parameter int unsigned DEPTH = ilfc_pkg::DepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ilfc_pkg::KindW-1:0]   kind_i,
  input  logic [ilfc_pkg::PosW-1:0]    position_i,
  input  logic signed [ilfc_pkg::WordW-1:0] item_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [ilfc_pkg::WordW-1:0] read_value_o,
  output logic [ilfc_pkg::StatusW-1:0] status_o,
  output logic [ilfc_pkg::CountW-1:0]  item_count_o,
  output logic [ilfc_pkg::CapW-1:0]    capacity_now_o
);
  import ilfc_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned CW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (CW > PosW) ? CW : PosW;
  localparam int unsigned EW   = (CW > CapW) ? CW : CapW;

  state_e state_q, state_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [CapW-1:0]  cap_cur_q, cap_cur_d, cap_prev_q, cap_prev_d, cap_pp_q, cap_pp_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic             up_q, up_d, first_q, first_d, cap_first_q, cap_first_d;
  logic             pend_q, pend_d, pend_cap_q, pend_cap_d, pend_wr_q, pend_wr_d;
  logic [AW-1:0]    pend_addr_q, pend_addr_d;
  logic             fin_wr_q, fin_wr_d;
  logic [AW-1:0]    fin_addr_q, fin_addr_d;
  logic [WordW-1:0] fin_data_q, fin_data_d;
  logic [WordW-1:0] rdv_q, rdv_d;
  status_e          status_q, status_d;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_val_q, out_val_d;
  status_e          out_status_q, out_status_d;
  logic [CountW-1:0] out_count_q, out_count_d;
  logic [CapW-1:0]  out_cap_q, out_cap_d;

  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [WordW-1:0] wdata, rdata;

  logic [CMPW-1:0]  pos_x, fill_x, span;
  logic [AW-1:0]    pos_a;
  logic [CW-1:0]    fill_m1;
  logic             grow_en, shrink_en;
  logic [CapW:0]    cap_sum;
  logic [CapW-1:0]  grow_cur, shrink_pp;
  logic [EW-1:0]    fill_e;
  logic             accept, out_free;

  ilfc_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign pos_x   = CMPW'(position_i);
  assign fill_x  = CMPW'(fill_q);
  assign span    = fill_x - pos_x;
  assign pos_a   = pos_x[AW-1:0];
  assign fill_m1 = fill_q - CW'(1);
  assign fill_e  = EW'(fill_q);

  assign grow_en   = EW'(fill_q) >= EW'(cap_cur_q);
  assign cap_sum   = {1'b0, cap_prev_q} + {1'b0, cap_cur_q};
  assign grow_cur  = (cap_sum > {1'b0, CapMax}) ? CapMax : cap_sum[CapW-1:0];
  assign shrink_en = EW'(fill_m1) < EW'(cap_pp_q);
  assign shrink_pp = (cap_prev_q > cap_pp_q) ? (cap_prev_q - cap_pp_q) : CapOne;

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    cap_cur_d   = cap_cur_q;
    cap_prev_d  = cap_prev_q;
    cap_pp_d    = cap_pp_q;
    cnt_d       = cnt_q;
    rd_ptr_d    = rd_ptr_q;
    up_d        = up_q;
    first_d     = first_q;
    cap_first_d = cap_first_q;
    pend_d      = 1'b0;
    pend_cap_d  = pend_cap_q;
    pend_wr_d   = pend_wr_q;
    pend_addr_d = pend_addr_q;
    fin_wr_d    = fin_wr_q;
    fin_addr_d  = fin_addr_q;
    fin_data_d  = fin_data_q;
    rdv_d       = rdv_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_val_d   = out_val_q;
    out_status_d = out_status_q;
    out_count_d = out_count_q;
    out_cap_d   = out_cap_q;
    we    = 1'b0;
    waddr = pend_addr_q;
    wdata = rdata;
    re    = 1'b0;
    raddr = rd_ptr_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d     = S_SHIFT;
          cnt_d       = '0;
          first_d     = 1'b1;
          cap_first_d = 1'b0;
          up_d        = 1'b0;
          fin_wr_d    = 1'b0;
          fin_data_d  = item_value_i;
          rdv_d       = '0;
          status_d    = ST_OK;
          case (kind_i)
            KIND_INSERT: begin
              if (pos_x > fill_x) begin
                status_d = ST_INDEX;
              end else if (fill_q == CW'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                cnt_d      = span[CW-1:0];
                rd_ptr_d   = fill_m1[AW-1:0];
                fin_wr_d   = 1'b1;
                fin_addr_d = pos_a;
                fill_d     = fill_q + CW'(1);
                if (grow_en) begin
                  cap_pp_d   = cap_prev_q;
                  cap_prev_d = cap_cur_q;
                  cap_cur_d  = grow_cur;
                end
              end
            end
            KIND_REMOVE: begin
              if (pos_x >= fill_x) begin
                status_d = ST_INDEX;
              end else begin
                cnt_d       = span[CW-1:0];
                rd_ptr_d    = pos_a;
                up_d        = 1'b1;
                cap_first_d = 1'b1;
                fill_d      = fill_m1;
                if (shrink_en) begin
                  cap_cur_d  = cap_prev_q;
                  cap_prev_d = cap_pp_q;
                  cap_pp_d   = shrink_pp;
                end
              end
            end
            KIND_LOOKUP: begin
              if (pos_x >= fill_x) begin
                status_d = ST_INDEX;
              end else begin
                cnt_d       = CW'(1);
                rd_ptr_d    = pos_a;
                cap_first_d = 1'b1;
              end
            end
            KIND_PUSH: begin
              if (fill_q == CW'(DEPTH)) begin
                status_d = ST_FULL;
              end else begin
                fin_wr_d   = 1'b1;
                fin_addr_d = fill_q[AW-1:0];
                fill_d     = fill_q + CW'(1);
                if (grow_en) begin
                  cap_pp_d   = cap_prev_q;
                  cap_prev_d = cap_cur_q;
                  cap_cur_d  = grow_cur;
                end
              end
            end
            KIND_POP: begin
              if (fill_q == '0) begin
                status_d = ST_UNDER;
              end else begin
                cnt_d       = CW'(1);
                rd_ptr_d    = fill_m1[AW-1:0];
                cap_first_d = 1'b1;
                fill_d      = fill_m1;
                if (shrink_en) begin
                  cap_cur_d  = cap_prev_q;
                  cap_prev_d = cap_pp_q;
                  cap_pp_d   = shrink_pp;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SHIFT: begin
        if (pend_q) begin
          if (pend_wr_q) begin
            we = 1'b1;
          end
          if (pend_cap_q) begin
            rdv_d = rdata;
          end
        end
        if (cnt_q != '0) begin
          re          = 1'b1;
          pend_d      = 1'b1;
          pend_cap_d  = cap_first_q && first_q;
          pend_wr_d   = !(cap_first_q && first_q);
          pend_addr_d = up_q ? (rd_ptr_q - AW'(1)) : (rd_ptr_q + AW'(1));
          rd_ptr_d    = up_q ? (rd_ptr_q + AW'(1)) : (rd_ptr_q - AW'(1));
          cnt_d       = cnt_q - CW'(1);
          first_d     = 1'b0;
        end else if (!pend_q) begin
          if (fin_wr_q) begin
            we    = 1'b1;
            waddr = fin_addr_q;
            wdata = fin_data_q;
          end
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_val_d    = rdv_q;
          out_status_d = status_q;
          out_count_d  = fill_e[CountW-1:0];
          out_cap_d    = cap_cur_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      cap_cur_q   <= CapOne;
      cap_prev_q  <= CapOne;
      cap_pp_q    <= CapOne;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      cap_cur_q   <= cap_cur_d;
      cap_prev_q  <= cap_prev_d;
      cap_pp_q    <= cap_pp_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_ptr_q     <= rd_ptr_d;
    up_q         <= up_d;
    first_q      <= first_d;
    cap_first_q  <= cap_first_d;
    pend_cap_q   <= pend_cap_d;
    pend_wr_q    <= pend_wr_d;
    pend_addr_q  <= pend_addr_d;
    fin_wr_q     <= fin_wr_d;
    fin_addr_q   <= fin_addr_d;
    fin_data_q   <= fin_data_d;
    rdv_q        <= rdv_d;
    status_q     <= status_d;
    out_val_q    <= out_val_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_cap_q    <= out_cap_d;
  end

  assign out_valid_o    = out_valid_q;
  assign read_value_o   = out_val_q;
  assign status_o       = out_status_q;
  assign item_count_o   = out_count_q;
  assign capacity_now_o = out_cap_q;

endmodule
